// ----- hdl/kmsc_pkg.sv -----
package kmsc_pkg;

  // Matrix geometry
  localparam int unsigned ROWS    = 6;
  localparam int unsigned COLUMNS = 9;
  localparam int unsigned ROW_W   = 3;
  localparam int unsigned COL_W   = 4;
  localparam int unsigned KEY_W   = 7;

  // Named keycodes that appear in the matrix
  localparam logic [KEY_W-1:0] KEY_F1      = 7'd59;
  localparam logic [KEY_W-1:0] KEY_SPC     = 7'd57;
  localparam logic [KEY_W-1:0] KEY_RETURN  = 7'd28;
  localparam logic [KEY_W-1:0] KEY_TAB     = 7'd15;
  localparam logic [KEY_W-1:0] KEY_SOLIDUS = 7'd53;

  // Keycode for each row and column
  localparam logic [KEY_W-1:0] KEY_TABLE [ROWS][COLUMNS] = '{
    '{KEY_F1, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66, 7'd67},
    '{7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10},
    '{7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24},
    '{7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd38},
    '{7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50, KEY_TAB, KEY_RETURN},
    '{KEY_SPC, 7'd42, 7'd54, 7'd29, 7'd56, 7'd43, 7'd51, 7'd52, KEY_SOLIDUS}
  };

  // One column reading after comparison with the stored one
  typedef struct packed {
    logic [ROWS-1:0]    diff;
    logic [ROWS-1:0]    now;
    logic [COL_W-1:0]   col;
    logic [COLUMNS-1:0] strobe;
  } scan_item_t;

endpackage

// ----- hdl/kmsc_scan.sv -----
module kmsc_scan
  import kmsc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [ROWS-1:0] row_sense_i,
  output scan_item_t      item_o
);

  logic [ROWS-1:0]  readings_q [COLUMNS];
  logic [COL_W-1:0] col_q;
  logic [COL_W-1:0] col_next;

  // Wrap the column after the last one
  assign col_next = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + COL_W'(1);

  // Compare the reading with the stored one for this column
  always_comb begin
    item_o.now    = row_sense_i;
    item_o.diff   = row_sense_i ^ readings_q[col_q];
    item_o.col    = col_q;
    item_o.strobe = ~(COLUMNS'(1) << col_next);
  end

  // Store the reading and advance the column on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < COLUMNS; c++) readings_q[c] <= '1;
      col_q <= '0;
    end else if (accept_i) begin
      readings_q[col_q] <= row_sense_i;
      col_q             <= col_next;
    end
  end

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < COL_W'(COLUMNS))
    else $error("column index out of range");

  a_col_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> col_q == ($past(col_q) == COL_W'(COLUMNS - 1) ? '0 : $past(col_q) + 1'b1))
    else $error("column did not advance on transfer");

  a_strobe_onecold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(~item_o.strobe) == 1)
    else $error("column strobe must have exactly one bit cleared");

  a_reading_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> readings_q[$past(col_q)] == $past(row_sense_i))
    else $error("reading not stored for scanned column");

endmodule

// ----- hdl/kmsc_emit.sv -----
module kmsc_emit
  import kmsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               accept_o,
  input  scan_item_t         item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               event_valid_o,
  output logic [KEY_W-1:0]   keycode_o,
  output logic               pressed_o,
  output logic [ROW_W-1:0]   key_row_o,
  output logic [COL_W-1:0]   key_column_o,
  output logic [COLUMNS-1:0] column_strobe_o,
  output logic               last_o
);

  logic       pend_valid_q;
  scan_item_t pend_q;
  logic       out_valid_q;

  logic            out_free;
  logic            advance;
  logic            has_event;
  logic [ROW_W-1:0] sel_row;
  logic [ROWS-1:0]  rest;
  logic            pend_last;

  // Pick the lowest changed row
  always_comb begin
    sel_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (pend_q.diff[r]) sel_row = ROW_W'(r);
    end
  end

  assign has_event = |pend_q.diff;
  assign rest      = pend_q.diff & ~(ROWS'(1) << sel_row);
  assign pend_last = (rest == '0);

  // Handshake: move one result whenever the output register is free
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = pend_valid_q && out_free;
  assign in_stall_o = pend_valid_q && !(advance && pend_last);
  assign accept_o   = in_valid_i && !in_stall_o;

  // Hold the item being split into events
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (accept_o) begin
      pend_valid_q <= 1'b1;
    end else if (advance && pend_last) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      pend_q <= item_i;
    end else if (advance) begin
      pend_q.diff <= rest;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_valid_o   <= has_event;
      keycode_o       <= has_event ? KEY_TABLE[sel_row][pend_q.col] : '0;
      pressed_o       <= has_event & ~pend_q.now[sel_row];
      key_row_o       <= has_event ? sel_row : '0;
      key_column_o    <= pend_q.col;
      column_strobe_o <= pend_q.strobe;
      last_o          <= pend_last;
    end
  end

  assign out_valid_o = out_valid_q;

  a_idle_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !event_valid_o |-> last_o)
    else $error("no-change result must be the last one");

  a_mask_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !pend_last && !accept_o |=>
      $countones(pend_q.diff) == $countones($past(pend_q.diff)) - 1)
    else $error("pending change mask did not lose one row");

  a_accept_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_o && pend_valid_q |-> advance && pend_last)
    else $error("new item taken over unfinished events");

endmodule

// ----- hdl/key_matrix_scan_change_events_unit.sv -----
// Key matrix scanner, 6 rows by 9 columns, with per-column change events.
//
// Drive column_strobe_o (active low) onto the matrix, wait for the rows to
// settle, then transfer the active-low row reading on row_sense_i with
// in_valid_i. Each transfer is compared with the last reading of the same
// column; one result is produced for each changed row, lowest row first,
// carrying the keycode and a pressed flag. An unchanged column yields a
// single result with event_valid_o low. last_o marks the final result of
// each input transfer; column_strobe_o on it selects the next column.
//
// The input transfer is held in a pending register, and each result is
// registered in the single result register before it moves out. Results
// leave at one result per cycle while out_stall_i is low, one per changed
// row and at least one per item. The next item is taken in the cycle its
// predecessor's last result enters the result register. A valid result
// holds while out_stall_i is high, and in_stall_o stays high while an item
// still has results waiting to move. Reset marks every key released and
// selects column 0; the result outputs carry no strobe until the first
// result, so drive column 0 first after reset.
module key_matrix_scan_change_events_unit
  import kmsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ROWS-1:0]    row_sense_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               event_valid_o,
  output logic [KEY_W-1:0]   keycode_o,
  output logic               pressed_o,
  output logic [ROW_W-1:0]   key_row_o,
  output logic [COL_W-1:0]   key_column_o,
  output logic [COLUMNS-1:0] column_strobe_o,
  output logic               last_o
);

  logic       accept;
  scan_item_t item;

  // Column state and comparison
  kmsc_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .row_sense_i (row_sense_i),
    .item_o      (item)
  );

  // Event splitting and result register
  kmsc_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .accept_o        (accept),
    .item_i          (item),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_valid_o   (event_valid_o),
    .keycode_o       (keycode_o),
    .pressed_o       (pressed_o),
    .key_row_o       (key_row_o),
    .key_column_o    (key_column_o),
    .column_strobe_o (column_strobe_o),
    .last_o          (last_o)
  );

endmodule

// ----- dv/tb.sv -----
module tb;
  import kmsc_pkg::*;

  localparam int unsigned LIMIT        = 200000;
  localparam int unsigned RANDOM_ITEMS = 192;
  localparam int unsigned CALM_ITEMS   = 40;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned REPORT_MAX   = 10;

  // Keycode per matrix position, row-major
  localparam bit [KEY_W-1:0] MATRIX_CODES [ROWS][COLUMNS] = '{
    '{KEY_F1, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66, 7'd67},
    '{7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10},
    '{7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24},
    '{7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd38},
    '{7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50, KEY_TAB, KEY_RETURN},
    '{KEY_SPC, 7'd42, 7'd54, 7'd29, 7'd56, 7'd43, 7'd51, 7'd52, KEY_SOLIDUS}
  };

  // Opening sweep: two passes over all columns, every row pressed and released
  localparam bit [ROWS-1:0] OPENING [18] = '{
    6'h1E, 6'h00, 6'h3F, 6'h2A, 6'h15, 6'h3E, 6'h3D, 6'h2F, 6'h0F,
    6'h3F, 6'h3F, 6'h00, 6'h15, 6'h15, 6'h3B, 6'h37, 6'h1F, 6'h3F
  };

  typedef struct packed {
    logic               ev;
    logic [KEY_W-1:0]   code;
    logic               press;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [COLUMNS-1:0] strobe;
    logic               last;
  } key_event_t;

  // Tracks the matrix state and the key events still owed by the block
  class scan_scoreboard;
    bit [ROWS-1:0] readings [COLUMNS];
    int unsigned   column;
    key_event_t    pending [$];
    int unsigned   failures;
    int unsigned   transfers;
    int unsigned   presses;
    int unsigned   releases;
    int unsigned   unchanged;

    function new();
      foreach (readings[c]) readings[c] = '1;
      column = 0;
    endfunction

    function bit [ROWS-1:0] stored_now();
      return readings[column];
    endfunction

    // Expand one row reading into its key events
    function void note_reading(bit [ROWS-1:0] now);
      int unsigned   col;
      int unsigned   nxt;
      int unsigned   changes;
      int unsigned   emitted;
      bit [ROWS-1:0] diff;
      key_event_t    e;
      col = (column < COLUMNS) ? column : 0;
      nxt = (col + 1 < COLUMNS) ? col + 1 : 0;
      diff = now ^ readings[col];
      changes = $countones(diff);
      emitted = 0;
      transfers++;
      for (int r = 0; r < ROWS; r++) begin
        if (diff[r]) begin
          emitted++;
          e.ev     = 1'b1;
          e.code   = MATRIX_CODES[r][col];
          e.press  = ~now[r];
          e.row    = ROW_W'(r);
          e.col    = COL_W'(col);
          e.strobe = ~(COLUMNS'(1) << nxt);
          e.last   = (emitted == changes);
          if (e.press) presses++;
          else releases++;
          pending.push_back(e);
        end
      end
      if (changes == 0) begin
        e        = '0;
        e.col    = COL_W'(col);
        e.strobe = ~(COLUMNS'(1) << nxt);
        e.last   = 1'b1;
        unchanged++;
        pending.push_back(e);
      end
      readings[col] = now;
      column = nxt;
    endfunction

    function string show(key_event_t e);
      return $sformatf("ev=%0b key=%0d pressed=%0b row=%0d col=%0d strobe=%03h last=%0b",
                       e.ev, e.code, e.press, e.row, e.col, e.strobe, e.last);
    endfunction

    // Compare one result transfer against the oldest expected event
    function void check_event(key_event_t got);
      key_event_t exp;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("[%0t] unexpected result: %s", $realtime, show(got));
      end else begin
        exp = pending.pop_front();
        if (got !== exp) begin
          failures++;
          if (failures <= REPORT_MAX) begin
            $display("[%0t] mismatch", $realtime);
            $display("  expected %s", show(exp));
            $display("  actual   %s", show(got));
          end
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [ROWS-1:0]    row_sense_i = '1;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               event_valid_o;
  logic [KEY_W-1:0]   keycode_o;
  logic               pressed_o;
  logic [ROW_W-1:0]   key_row_o;
  logic [COL_W-1:0]   key_column_o;
  logic [COLUMNS-1:0] column_strobe_o;
  logic               last_o;

  scan_scoreboard sb = new();
  bit             calm = 1'b0;
  int unsigned    cycles = 0;
  int unsigned    hold_left = 0;
  int unsigned    quiet_left = 0;

  key_matrix_scan_change_events_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .row_sense_i    (row_sense_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_valid_o  (event_valid_o),
    .keycode_o      (keycode_o),
    .pressed_o      (pressed_o),
    .key_row_o      (key_row_o),
    .key_column_o   (key_column_o),
    .column_strobe_o(column_strobe_o),
    .last_o         (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stall the result side in bursts, with occasional quiet stretches
  always @(negedge clk_i) begin
    if (!rst_ni || calm) begin
      hold_left = 0;
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (quiet_left > 0) begin
      quiet_left--;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 29) == 0) begin
      quiet_left = $urandom_range(20, 40);
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      hold_left = $urandom_range(0, 6);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watch for timeout and check every result transfer
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d events outstanding", cycles, sb.pending.size());
      $display("Verification failed");
      $finish;
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_event({event_valid_o, keycode_o, pressed_o, key_row_o, key_column_o,
                      column_strobe_o, last_o});
    end
  end

  // Transfer one row reading, with an optional idle burst ahead of it
  task automatic send_reading(bit [ROWS-1:0] value);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    row_sense_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_reading(value);
    @(negedge clk_i);
  endtask

  // Pick a reading: mostly small changes against the stored one
  function automatic bit [ROWS-1:0] pick_reading();
    bit [ROWS-1:0] base;
    base = sb.stored_now();
    case ($urandom_range(0, 9))
      0, 1:    return base;
      2, 3, 4, 5: return base ^ (ROWS'(1) << $urandom_range(0, ROWS - 1));
      6, 7:    return base ^ ((ROWS'(1) << $urandom_range(0, ROWS - 1)) |
                              (ROWS'(1) << $urandom_range(0, ROWS - 1)) |
                              (ROWS'(1) << $urandom_range(0, ROWS - 1)));
      default: return ROWS'($urandom_range(0, 63));
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (OPENING[i]) send_reading(OPENING[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_reading(pick_reading());
    end
    in_valid_i <= 1'b0;

    // Drain outstanding events, then allow for stray results
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d row readings over %0d scan passes: %0d presses, %0d releases, %0d quiet",
             sb.transfers, sb.transfers / COLUMNS, sb.presses, sb.releases, sb.unchanged);
    $display("%0d failing result checks", sb.failures);
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
